// ===== design/tfn_pkg.sv =====
// Shared widths, pipeline data types and helpers for the triangle face normal block.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int OUT_WIDTH     = 16;

   // Edge, product, cross and magnitude widths.
   localparam int EW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * EW;
   localparam int NW  = PW + 1;
   localparam int MW  = NW - 1;
   // Split of a magnitude into high and low halves for squaring.
   localparam int HW  = (MW + 1) / 2;
   localparam int LW  = MW - HW;
   localparam int SQW = 2 * MW;
   localparam int SW  = SQW + 2;
   // Working width of the digit recurrence.
   localparam int AW  = SW + 2 * OUT_FRAC_BITS + 5;
   localparam int QW  = OUT_FRAC_BITS + 1;
   localparam int NCELL = OUT_FRAC_BITS + 1;
   localparam int BPW = $clog2(NCELL);
   // Width used for signing and saturating a result component.
   localparam int VW  = ((QW + 1 > OUT_WIDTH) ? QW + 1 : OUT_WIDTH) + 1;

   typedef struct packed {
      logic [AW-1:0] d;   // remainder: target minus (2q-1)^2 times the squared length
      logic [AW-1:0] p;   // (2q-1) times the squared length, two's complement
      logic [QW-1:0] q;
      logic          neg;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lane;
      logic [SW-1:0]  s;
      logic           degen;
      logic           last;
   } cell_data_type;

   // Result bit resolved by the cell at position c of the chain.
   function automatic logic [BPW-1:0] cell_bit(input int c);
      return BPW'(OUT_FRAC_BITS - c);
   endfunction

endpackage
`default_nettype wire

// ===== design/triangle_face_normal.sv =====
// Triangle face unit normal: top level tying the front pipeline, cell chain and output.
// Depends on tfn_pkg, tfn_front, tfn_cell and tfn_out.
//
// Usage: one triangle request (three signed vertices and a last marker) enters on the
// req_ channel with a valid/ready handshake. Each request yields one response on the
// rsp_ channel: the unit normal as signed Q1.14 components rounded to nearest, a flag
// for a degenerate triangle (zero cross product, zero normal) and the copied marker.
// Each request passes through 23 registers in a row, the first loaded at acceptance:
// 7 front stages (edges, cross products, magnitudes, split squares, square sums,
// squared length, recurrence setup), one cell per result bit (15 cells), and the
// output register. Throughput is one request per clock while rsp_ready stays high;
// every stage is a register with its own valid bit.
// When the receiver stalls, the response holds in the output register and requests
// keep entering until the stages behind it have filled; req_ready then drops.
// Reset (synchronous, active high) empties all stages; nothing else is held.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_ax,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_ay,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_az,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_bx,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_by_coord,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_bz,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_cx,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_cy,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]   req_cz,
   input  wire logic                                     req_last_face,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed [tfn_pkg::OUT_WIDTH-1:0]          rsp_norm_x,
   output logic signed [tfn_pkg::OUT_WIDTH-1:0]          rsp_norm_y,
   output logic signed [tfn_pkg::OUT_WIDTH-1:0]          rsp_norm_z,
   output logic                                          rsp_degenerate,
   output logic                                          rsp_last_out
);

   logic signed [tfn_pkg::COORD_WIDTH-1:0] va [3], vb [3], vc [3];
   logic signed [tfn_pkg::OUT_WIDTH-1:0]   norm [3];

   logic                   chain_valid [tfn_pkg::NCELL+1];
   logic                   chain_ready [tfn_pkg::NCELL+1];
   tfn_pkg::cell_data_type chain_data  [tfn_pkg::NCELL+1];

   assign va[0] = req_ax;
   assign va[1] = req_ay;
   assign va[2] = req_az;
   assign vb[0] = req_bx;
   assign vb[1] = req_by_coord;
   assign vb[2] = req_bz;
   assign vc[0] = req_cx;
   assign vc[1] = req_cy;
   assign vc[2] = req_cz;

   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .va        (va),
      .vb        (vb),
      .vc        (vc),
      .in_last   (req_last_face),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Cell c resolves result bit OUT_FRAC_BITS - c, most significant first.
   for (genvar c = 0; c < tfn_pkg::NCELL; c++) begin : g_cell
      tfn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bit_pos   (tfn_pkg::cell_bit(c)),
         .in_valid  (chain_valid[c]),
         .in_ready  (chain_ready[c]),
         .in_data   (chain_data[c]),
         .out_valid (chain_valid[c+1]),
         .out_ready (chain_ready[c+1]),
         .out_data  (chain_data[c+1])
      );
   end

   tfn_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[tfn_pkg::NCELL]),
      .in_ready  (chain_ready[tfn_pkg::NCELL]),
      .in_data   (chain_data[tfn_pkg::NCELL]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_norm  (norm),
      .out_degen (rsp_degenerate),
      .out_last  (rsp_last_out)
   );

   assign rsp_norm_x = norm[0];
   assign rsp_norm_y = norm[1];
   assign rsp_norm_z = norm[2];

endmodule
`default_nettype wire

// ===== design/tfn_front.sv =====
// Front pipeline: edge vectors, cross product, component squares and squared length.
// Depends on tfn_pkg. Seven registered stages with a per-stage valid and ready chain.
`timescale 1ns / 1ps
`default_nettype none
module tfn_front (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      in_valid,
   output logic                                           in_ready,
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]    va [3],
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]    vb [3],
   input  wire logic signed [tfn_pkg::COORD_WIDTH-1:0]    vc [3],
   input  wire logic                                      in_last,
   output logic                                           out_valid,
   input  wire logic                                      out_ready,
   output tfn_pkg::cell_data_type                         out_data
);

   localparam int NSTG = 7;

   logic [NSTG-1:0] v_ff, v_in, rdy, ld;
   logic [NSTG-2:0] last_ff;

   logic signed [tfn_pkg::EW-1:0]  e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [tfn_pkg::PW-1:0]  pa_ff [3], pb_ff [3], pa_in [3], pb_in [3];
   logic signed [tfn_pkg::NW-1:0]  n_w [3];
   logic [tfn_pkg::MW-1:0]         mag_ff [3], mag_in [3];
   logic [2:0]                     neg_ff [2:5];
   logic [2:0]                     neg_in;
   logic [2*tfn_pkg::HW-1:0]       hh_ff [3], hh_in [3];
   logic [tfn_pkg::HW+tfn_pkg::LW-1:0] hl_ff [3], hl_in [3];
   logic [2*tfn_pkg::LW-1:0]       ll_ff [3], ll_in [3];
   logic [tfn_pkg::SQW-1:0]        sq_ff [3], sq_in [3], sqf_ff [3];
   logic [tfn_pkg::SW-1:0]         s_ff, s_in;
   tfn_pkg::cell_data_type         g_ff, g_in;

   always_comb begin
      rdy[NSTG-1] = !v_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      ld[0] = rdy[0] && in_valid;
      v_in[0] = rdy[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         ld[i] = rdy[i] && v_ff[i-1];
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NSTG-1];
   assign out_data  = g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Datapath next values.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = tfn_pkg::EW'(vb[i]) - tfn_pkg::EW'(va[i]);
         e2_in[i] = tfn_pkg::EW'(vc[i]) - tfn_pkg::EW'(va[i]);
      end
      pa_in[0] = e1_ff[1] * e2_ff[2];
      pb_in[0] = e1_ff[2] * e2_ff[1];
      pa_in[1] = e1_ff[2] * e2_ff[0];
      pb_in[1] = e1_ff[0] * e2_ff[2];
      pa_in[2] = e1_ff[0] * e2_ff[1];
      pb_in[2] = e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         n_w[i] = tfn_pkg::NW'(pa_ff[i]) - tfn_pkg::NW'(pb_ff[i]);
         neg_in[i] = n_w[i][tfn_pkg::NW-1];
         mag_in[i] = neg_in[i] ? tfn_pkg::MW'(-n_w[i]) : tfn_pkg::MW'(n_w[i]);
         hh_in[i] = mag_ff[i][tfn_pkg::MW-1:tfn_pkg::LW] * mag_ff[i][tfn_pkg::MW-1:tfn_pkg::LW];
         hl_in[i] = mag_ff[i][tfn_pkg::MW-1:tfn_pkg::LW] * mag_ff[i][tfn_pkg::LW-1:0];
         ll_in[i] = mag_ff[i][tfn_pkg::LW-1:0] * mag_ff[i][tfn_pkg::LW-1:0];
         sq_in[i] = (tfn_pkg::SQW'(hh_ff[i]) << (2 * tfn_pkg::LW))
                  + (tfn_pkg::SQW'(hl_ff[i]) << (tfn_pkg::LW + 1))
                  + tfn_pkg::SQW'(ll_ff[i]);
      end
      s_in = tfn_pkg::SW'(sq_ff[0]) + tfn_pkg::SW'(sq_ff[1]) + tfn_pkg::SW'(sq_ff[2]);
      // Recurrence starts from q = 0, that is 2q-1 = -1.
      for (int i = 0; i < 3; i++) begin
         g_in.lane[i].d = (tfn_pkg::AW'(sqf_ff[i]) << (2 * tfn_pkg::OUT_FRAC_BITS + 2))
                        - tfn_pkg::AW'(s_ff);
         g_in.lane[i].p = '0 - tfn_pkg::AW'(s_ff);
         g_in.lane[i].q = '0;
         g_in.lane[i].neg = neg_ff[5][i];
      end
      g_in.s = s_ff;
      g_in.degen = (s_ff == '0);
      g_in.last = last_ff[5];
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         last_ff[0] <= in_last;
      end
      if (ld[1]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         last_ff[1] <= last_ff[0];
      end
      if (ld[2]) begin
         mag_ff <= mag_in;
         neg_ff[2] <= neg_in;
         last_ff[2] <= last_ff[1];
      end
      if (ld[3]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         neg_ff[3] <= neg_ff[2];
         last_ff[3] <= last_ff[2];
      end
      if (ld[4]) begin
         sq_ff <= sq_in;
         neg_ff[4] <= neg_ff[3];
         last_ff[4] <= last_ff[3];
      end
      if (ld[5]) begin
         s_ff <= s_in;
         sqf_ff <= sq_ff;
         neg_ff[5] <= neg_ff[4];
         last_ff[5] <= last_ff[4];
      end
      if (ld[6]) begin
         g_ff <= g_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tfn_cell.sv =====
// One cell of the normalization chain: decides one result bit for all three components.
// Depends on tfn_pkg. Holds one request and passes it to its neighbor when that neighbor is ready.
`timescale 1ns / 1ps
`default_nettype none
module tfn_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [tfn_pkg::BPW-1:0]      bit_pos,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire tfn_pkg::cell_data_type       in_data,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output tfn_pkg::cell_data_type            out_data
);

   logic                   v_ff, v_in;
   tfn_pkg::cell_data_type data_ff, data_in;
   logic [tfn_pkg::BPW+1:0] sh_p, sh_s, sh_a;
   logic [tfn_pkg::AW-1:0] s_w;
   logic [tfn_pkg::AW-1:0] delta [3];
   logic [tfn_pkg::AW-1:0] rem [3];
   logic [2:0]             take;

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = data_ff;
   assign v_in      = in_ready ? in_valid : v_ff;

   // Trying bit b moves 2q-1 up by 2^(b+1); the squared term grows by
   // 2^(b+2)*(2q-1)*S + 2^(2b+2)*S, so no multiplier is needed.
   always_comb begin
      sh_p = {2'b00, bit_pos} + 2'd2;
      sh_s = {1'b0, bit_pos, 1'b0} + 2'd2;
      sh_a = {2'b00, bit_pos} + 2'd1;
      s_w  = tfn_pkg::AW'(in_data.s);
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         delta[i] = (in_data.lane[i].p << sh_p) + (s_w << sh_s);
         rem[i]   = in_data.lane[i].d - delta[i];
         // Once q has reached one, no lower bit may be added.
         take[i]  = !in_data.lane[i].q[tfn_pkg::QW-1] && !rem[i][tfn_pkg::AW-1];
         if (take[i]) begin
            data_in.lane[i].d = rem[i];
            data_in.lane[i].p = in_data.lane[i].p + (s_w << sh_a);
            data_in.lane[i].q = in_data.lane[i].q | (tfn_pkg::QW'(1) << bit_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tfn_out.sv =====
// Output register: applies sign, degenerate zeroing and saturation to the chain result.
// Depends on tfn_pkg. Holds the response until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module tfn_out (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire tfn_pkg::cell_data_type             in_data,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output logic signed [tfn_pkg::OUT_WIDTH-1:0]    out_norm [3],
   output logic                                    out_degen,
   output logic                                    out_last
);

   logic                                  v_ff, v_in;
   logic signed [tfn_pkg::OUT_WIDTH-1:0]  norm_ff [3], norm_in [3];
   logic                                  degen_ff, last_ff;
   logic signed [tfn_pkg::VW-1:0]         val [3];
   logic signed [tfn_pkg::VW-1:0]         vmax, vmin;

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_norm  = norm_ff;
   assign out_degen = degen_ff;
   assign out_last  = last_ff;
   assign v_in      = in_ready ? in_valid : v_ff;

   always_comb begin
      vmax = tfn_pkg::VW'(2 ** (tfn_pkg::OUT_WIDTH - 1) - 1);
      vmin = -(tfn_pkg::VW'(2 ** (tfn_pkg::OUT_WIDTH - 1) - 1)) - tfn_pkg::VW'(1);
      for (int i = 0; i < 3; i++) begin
         val[i] = in_data.lane[i].neg ? -$signed(tfn_pkg::VW'(in_data.lane[i].q))
                                      : $signed(tfn_pkg::VW'(in_data.lane[i].q));
         if (in_data.degen) begin
            norm_in[i] = '0;
         end else if (val[i] > vmax) begin
            norm_in[i] = tfn_pkg::OUT_WIDTH'(vmax);
         end else if (val[i] < vmin) begin
            norm_in[i] = tfn_pkg::OUT_WIDTH'(vmin);
         end else begin
            norm_in[i] = tfn_pkg::OUT_WIDTH'(val[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         norm_ff  <= norm_in;
         degen_ff <= in_data.degen;
         last_ff  <= in_data.last;
      end
   end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for triangle_face_normal: directed and random triangles with random idling.
// Depends on tfn_pkg and the design; expected normals come from exact integer arithmetic.
`timescale 1ns / 1ps
module testbench;

   localparam int CW = tfn_pkg::COORD_WIDTH;
   localparam int FB = tfn_pkg::OUT_FRAC_BITS;
   localparam int OW = tfn_pkg::OUT_WIDTH;

   typedef struct {
      logic signed [CW-1:0] v [9];
      logic                 last;
   } face_type;

   typedef struct {
      logic signed [OW-1:0] nx, ny, nz;
      logic                 degen, last;
   } normal_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_ready = 0, rsp_valid;
   logic signed [CW-1:0] req_ax = 0, req_ay = 0, req_az = 0, req_bx = 0, req_by_coord = 0;
   logic signed [CW-1:0] req_bz = 0, req_cx = 0, req_cy = 0, req_cz = 0;
   logic req_last_face = 0;
   logic signed [OW-1:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic rsp_degenerate, rsp_last_out;

   normal_type normals_due [$];
   int mismatches = 0;
   bit no_idle = 0;
   int rsp_stall = 0;

   triangle_face_normal i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Rounded unit component: largest q with (2q-1)^2 * |N|^2 <= 4 * Ni^2 * 2^(2*FB).
   function automatic logic signed [OW-1:0] unit_component(logic signed [63:0] ni,
                                                            logic [127:0] len2);
      logic [63:0]  mag;
      logic [127:0] target, lhs;
      logic [31:0]  q, cand, k;
      logic signed [33:0] sv;
      mag = ni < 0 ? -ni : ni;
      target = (128'(mag) * 128'(mag)) << (2 * FB + 2);
      q = 0;
      for (int b = FB; b >= 0; b--) begin
         cand = q | (32'd1 << b);
         if (cand <= (32'd1 << FB)) begin
            k = 2 * cand - 1;
            lhs = len2 * 128'(k) * 128'(k);
            if (lhs <= target) q = cand;
         end
      end
      sv = ni < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q});
      if (sv > 32767) sv = 32767;
      if (sv < -32768) sv = -32768;
      return sv[OW-1:0];
   endfunction

   function automatic normal_type face_normal(face_type f);
      logic signed [63:0] e1 [3], e2 [3], n [3];
      logic [127:0] len2;
      normal_type r;
      for (int i = 0; i < 3; i++) begin
         e1[i] = 64'(f.v[3 + i]) - 64'(f.v[i]);
         e2[i] = 64'(f.v[6 + i]) - 64'(f.v[i]);
      end
      for (int i = 0; i < 3; i++)
         n[i] = e1[(i + 1) % 3] * e2[(i + 2) % 3] - e1[(i + 2) % 3] * e2[(i + 1) % 3];
      len2 = 0;
      for (int i = 0; i < 3; i++)
         len2 += 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(n[i] < 0 ? -n[i] : n[i]);
      r.last = f.last;
      if (len2 == 0) begin
         r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1;
      end else begin
         r.nx = unit_component(n[0], len2);
         r.ny = unit_component(n[1], len2);
         r.nz = unit_component(n[2], len2);
         r.degen = 0;
      end
      return r;
   endfunction

   task automatic send_face(face_type f);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_ax <= f.v[0]; req_ay <= f.v[1]; req_az <= f.v[2];
      req_bx <= f.v[3]; req_by_coord <= f.v[4]; req_bz <= f.v[5];
      req_cx <= f.v[6]; req_cy <= f.v[7]; req_cz <= f.v[8];
      req_last_face <= f.last;
      do @(posedge clock); while (!req_ready);
      normals_due.push_back(face_normal(f));
   endtask

   // Response side: compare each accepted response and draw the next stall.
   always @(posedge clock) begin
      normal_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (normals_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = normals_due.pop_front();
            if (rsp_norm_x !== e.nx || rsp_norm_y !== e.ny || rsp_norm_z !== e.nz ||
                rsp_degenerate !== e.degen || rsp_last_out !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d dg=%b l=%b got %0d %0d %0d dg=%b l=%b",
                           e.nx, e.ny, e.nz, e.degen, e.last, rsp_norm_x, rsp_norm_y,
                           rsp_norm_z, rsp_degenerate, rsp_last_out);
            end
         end
         rsp_stall = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (rsp_stall > 0 && !(rsp_valid && rsp_ready)) rsp_stall--;
      rsp_ready <= (rsp_stall == 0);
   end

   function automatic face_type make_face(int mode);
      face_type f;
      for (int i = 0; i < 9; i++) begin
         case (mode)
            0: f.v[i] = CW'($urandom);
            1: f.v[i] = CW'($signed($urandom_range(0, 64)) - 32);
            default: f.v[i] = $urandom_range(0, 1) ? CW'(16'sh7fff - $urandom_range(0, 3))
                                                 : CW'(16'sh8000 + $urandom_range(0, 3));
         endcase
      end
      f.last = 1'($urandom_range(0, 1));
      return f;
   endfunction

   task automatic test_extremes();
      face_type f;
      int pat [6] = '{32'h0, 32'h1ff, 32'h07, 32'h38, 32'h1c0, 32'h155};
      foreach (pat[p]) begin
         for (int i = 0; i < 9; i++) f.v[i] = pat[p][i] ? 16'sh7fff : 16'sh8000;
         f.last = p[0];
         send_face(f);
      end
      // Right triangles along the axes, one of them at full scale, and one irregular wide-range triangle.
      f.v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; f.last = 0; send_face(f);
      f.v = '{0, 0, 0, 0, 0, 1, 1, 0, 0}; f.last = 1; send_face(f);
      f.v = '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0}; send_face(f);
      f.v = '{3, 5, 7, 32767, -32768, 100, -32768, 32767, -32768}; send_face(f);
   endtask

   task automatic test_degenerate();
      face_type f;
      f.v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; f.last = 0; send_face(f);
      f.v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_face(f);
      f.v = '{-32768, -32768, -32768, -32768, -32768, -32768, 1, 2, 3}; f.last = 1;
      send_face(f);
      f.v = '{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767}; send_face(f);
      f.v = '{1, 2, 3, 2, 4, 6, 5, 10, 15}; send_face(f);
   endtask

   task automatic test_random(int count);
      face_type f;
      int k;
      for (int n = 0; n < count; n++) begin
         if (n % 300 == 0) no_idle = ($urandom_range(0, 2) == 0);
         k = $urandom_range(0, 9);
         if (k < 5) f = make_face(0);
         else if (k < 7) f = make_face(1);
         else if (k < 8) f = make_face(2);
         else begin
            // Collinear points: C lies on the line through A and B.
            f = make_face(1);
            k = $signed($urandom_range(0, 8)) - 4;
            for (int i = 0; i < 3; i++)
               f.v[6 + i] = CW'(f.v[i] + k * (f.v[3 + i] - f.v[i]));
         end
         send_face(f);
      end
      no_idle = 0;
   endtask

   task automatic test_drain_pause();
      req_valid <= 0;
      while (normals_due.size() != 0) @(posedge clock);
      test_random(20);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_degenerate();
      test_random(800);
      test_drain_pause();
      test_random(780);
      req_valid <= 0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
